/* rtl/core/quadrature_detent_decoder_core_assert.svh */
// ----------------------------------------------------------------------------
// quadrature detent decoder assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DETENT_DECODER_CORE_ASSERT_SVH
`define QUADRATURE_DETENT_DECODER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define QDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qdd assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define QDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qdd assertion failed");

`endif

/* rtl/core/qdd_pkg.sv */
// ----------------------------------------------------------------------------
// qdd_pkg
// widths, reset values and the transition step table of the detent decoder
// ----------------------------------------------------------------------------
`default_nettype none

package qdd_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned TurnW = 8;
  localparam int unsigned AccW  = 8;
  localparam int unsigned SpdW  = 5;

  localparam logic [SpdW-1:0] SpdReset    = 5'd4;
  localparam logic [1:0]      RestingPair = 2'b11;

  localparam logic OpSample = 1'b0;
  localparam logic OpLoad   = 1'b1;

  typedef logic signed [AccW-1:0] acc_t;

  // step for a {previous pair, current pair} transition: -1, 0 or +1
  function automatic logic signed [1:0] step_lookup(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/qdd_if.sv */
// ----------------------------------------------------------------------------
// qdd channel interfaces
// request channel (samples and position loads) and result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface qdd_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic                           clk_level;
  logic                           dt_level;
  logic signed [qdd_pkg::PosW-1:0] new_position;

  modport source (output valid, output opcode, output clk_level, output dt_level,
                  output new_position, input ready);
  modport sink (input valid, input opcode, input clk_level, input dt_level,
                input new_position, output ready);
endinterface

interface qdd_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [qdd_pkg::PosW-1:0]  position_now;
  logic signed [qdd_pkg::TurnW-1:0] detents_turned;

  modport source (output valid, output position_now, output detents_turned,
                  input ready);
  modport sink (input valid, input position_now, input detents_turned,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/quadrature_detent_decoder_core.sv */
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_core
// detent counter for a two-contact rotary encoder
// ----------------------------------------------------------------------------
// Each request is a contact sample or a position load and gives one result.
// A load, or a sample that does not land on a resting point, shows its result
// in the cycle after acceptance. A resting sample shows its result once the
// rounded step count is divided by steps_per_detent in a restoring divider
// that produces one quotient bit per cycle, followed by a final state that
// signs the quotient and adds it to the position. One request is in flight at
// a time: in_ch.ready is low from acceptance until the result is taken. A
// steps_per_detent of 0 counts as 1.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_detent_decoder_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [qdd_pkg::SpdW-1:0] cfg_wdata,
  qdd_in_if.sink                        in_ch,
  qdd_out_if.source                     out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam int unsigned QW = qdd_pkg::AccW;

  logic [1:0]                      state;
  logic [qdd_pkg::SpdW-1:0]        spd;
  logic [1:0]                      last_contacts;
  qdd_pkg::acc_t                   acc;
  logic signed [qdd_pkg::PosW-1:0]  position;
  logic signed [qdd_pkg::TurnW-1:0] last_turned;
  logic                            out_valid;
  logic                            neg;
  logic [QW-1:0]                   quo;
  logic [qdd_pkg::SpdW-1:0]        rem;
  logic [2:0]                      cnt;

  logic [qdd_pkg::SpdW-1:0]  spd_eff;
  logic [1:0]                pair;
  logic signed [QW:0]        acc_sum;
  qdd_pkg::acc_t             acc_sat;
  logic                      at_rest;
  logic [QW:0]               mag;
  logic [qdd_pkg::SpdW:0]    trial;
  logic                      trial_ge;
  logic [QW-1:0]             turned;
  logic                      accept;

  assign accept  = in_ch.valid && in_ch.ready;
  assign spd_eff = (spd == '0) ? qdd_pkg::SpdW'(1) : spd;
  assign pair    = {in_ch.clk_level, in_ch.dt_level};

  // saturating step accumulation
  always_comb begin
    acc_sum = {acc[QW-1], acc}
            + (QW+1)'(qdd_pkg::step_lookup({last_contacts, pair}));
    if (acc_sum > (QW+1)'(signed'(127))) begin
      acc_sat = 8'sd127;
    end else if (acc_sum < -(QW+1)'(signed'(128))) begin
      acc_sat = -8'sd128;
    end else begin
      acc_sat = acc_sum[QW-1:0];
    end
  end

  // resting point detection
  assign at_rest = (pair == qdd_pkg::RestingPair) || (spd_eff == qdd_pkg::SpdW'(1))
                || ((spd_eff == qdd_pkg::SpdW'(2)) && (pair == 2'b00));

  // magnitude rounded away from zero by half a detent
  always_comb begin
    if (acc_sat[QW-1]) begin
      mag = -{acc_sat[QW-1], acc_sat};
    end else begin
      mag = {1'b0, acc_sat};
    end
    mag = mag + (QW+1)'(spd_eff >> 1);
  end

  // shared compare/subtract unit of the restoring divider
  assign trial    = {rem, quo[QW-1]};
  assign trial_ge = trial >= {1'b0, spd_eff};

  // signed quotient
  assign turned = neg ? (~quo + QW'(1)) : quo;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      spd <= qdd_pkg::SpdReset;
    end else if (cfg_we) begin
      spd <= cfg_wdata;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_contacts <= qdd_pkg::RestingPair;
      acc           <= '0;
      position      <= '0;
      last_turned   <= '0;
      out_valid     <= 1'b0;
      cnt           <= '0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.opcode == qdd_pkg::OpLoad) begin
              position  <= in_ch.new_position;
              out_valid <= 1'b1;
            end else begin
              last_contacts <= pair;
              last_turned   <= '0;
              if (at_rest) begin
                acc   <= '0;
                neg   <= acc_sat[QW-1];
                quo   <= mag[QW-1:0];
                rem   <= '0;
                cnt   <= '0;
                state <= S_DIV;
              end else begin
                acc       <= acc_sat;
                out_valid <= 1'b1;
              end
            end
          end
        end
        S_DIV: begin
          if (trial_ge) begin
            rem <= qdd_pkg::SpdW'(trial - {1'b0, spd_eff});
          end else begin
            rem <= trial[qdd_pkg::SpdW-1:0];
          end
          quo <= {quo[QW-2:0], trial_ge};
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          last_turned <= turned;
          position    <= position + {{(qdd_pkg::PosW-QW){turned[QW-1]}}, turned};
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // handshake and result fields
  assign in_ch.ready           = (state == S_IDLE) && !out_valid;
  assign out_ch.valid          = out_valid;
  assign out_ch.position_now   = position;
  assign out_ch.detents_turned = last_turned;

endmodule

`default_nettype wire

/* rtl/core/qdd_checker.sv */
// ----------------------------------------------------------------------------
// qdd_checker
// port-level checks of the detent decoder, bound to quadrature_detent_decoder_core
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadrature_detent_decoder_core_assert.svh"

module qdd_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            in_opcode,
  input wire logic signed [qdd_pkg::PosW-1:0] in_new_position,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic signed [qdd_pkg::PosW-1:0] out_position_now
);

  // a pending result holds until taken
  `QDD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // one request in flight: busy right after acceptance
  `QDD_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  // no request taken while a result waits
  `QDD_ASSERT_NOW(a_no_req_with_result, out_valid, !in_ready)

  // a position load shows the loaded value in the next cycle
  `QDD_ASSERT_NEXT(a_load_result, in_valid && in_ready && in_opcode == qdd_pkg::OpLoad,
                   out_valid && out_position_now == $past(in_new_position))

endmodule

bind quadrature_detent_decoder_core qdd_checker u_qdd_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_opcode        (in_ch.opcode),
  .in_new_position  (in_ch.new_position),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_position_now (out_ch.position_now)
);

`default_nettype wire
